/* hdl/tpqd_pkg.sv */
// Shared types and constants for the throttled priority queue with id dedup.
// No dependencies; every other file imports this package.
package tpqd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WORDS    = 4;
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int LVL_W       = 25;
	localparam int ACC_W       = 27;

	localparam logic [23:0] BPT_RESET  = 24'(100 * 1024);
	localparam logic [23:0] BMAX_RESET = 24'(200 * 1024);
	localparam logic signed [ACC_W-1:0] BUCKET_LOW = -(ACC_W'(1) <<< 24);

	localparam logic [2:0] CFG_BYTES_PER_TICK = 3'd0;
	localparam logic [2:0] CFG_BYTES_MAX      = 3'd1;
	localparam logic [2:0] CFG_PRIO_ZERO      = 3'd2;
	localparam logic [2:0] CFG_NO_REPLACE     = 3'd3;
	localparam logic [2:0] CFG_NO_THROTTLE    = 3'd4;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] id_w0;
		logic signed [31:0] id_w1;
		logic signed [31:0] id_w2;
		logic signed [31:0] id_w3;
		logic signed [31:0] priority_req;
		logic [19:0]        byte_size;
		logic               link_busy;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_w0;
		logic signed [31:0] out_w1;
		logic signed [31:0] out_w2;
		logic signed [31:0] out_w3;
		logic signed [31:0] out_priority;
		logic [19:0]        out_size;
		logic               dropped;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [23:0] bytes_per_tick;
		logic [23:0] bytes_max;
		logic        prio_zero;
		logic        no_replace;
		logic        no_throttle;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_ADD_DO,
		ST_DR_CHK,
		ST_DR_SCAN,
		ST_DR_EMIT,
		ST_FINISH
	} back_state_t;

endpackage

/* hdl/tpqd_front.sv */
// Front end: takes requests and holds them in a short FIFO for the back end.
// Depends on tpqd_pkg.
module tpqd_front
	import tpqd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output in_item_t head
);

	in_item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

/* hdl/tpqd_back.sv */
// Back end: slot table, id match scan, min-search drain and token bucket.
// Depends on tpqd_pkg.
module tpqd_back
	import tpqd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cmd_valid,
	input  in_item_t  cmd,
	output logic      cmd_pop,
	output logic      result_valid,
	output out_item_t result
);

	back_state_t state_q, state_d;

	logic                     valid_q [QUEUE_DEPTH];
	logic signed [31:0]       id_q    [QUEUE_DEPTH][ID_WORDS];
	logic signed [31:0]       prio_q  [QUEUE_DEPTH];
	logic [19:0]              size_q  [QUEUE_DEPTH];

	in_item_t                 cur_q;
	logic [SLOT_W-1:0]        idx_q;
	logic                     hit_found_q, free_found_q, best_found_q;
	logic [SLOT_W-1:0]        hit_q, free_q, best_q;
	logic signed [31:0]       hit_prio_q, best_prio_q;
	logic signed [31:0]       best_ids_q [ID_WORDS];
	logic [19:0]              best_size_q;
	logic signed [LVL_W-1:0]  bucket_q;
	logic                     pend_valid_q;
	out_item_t                pend_q;
	logic                     res_valid_q;
	out_item_t                res_q;

	logic signed [31:0]       cur_ids [4];
	logic signed [31:0]       prio_eff;
	logic                     idx_last;
	logic                     id_match;
	logic                     better;
	logic                     lex_lt;
	logic                     can_drain;
	logic signed [ACC_W-1:0]  tick_sum, drain_diff;
	logic signed [31:0]       ins_prio;
	logic [SLOT_W-1:0]        ins_slot;
	logic                     ins_ok;
	out_item_t                drop_res, emit_res, fin_res;
	logic signed [31:0]       out_words [4];
	logic signed [31:0]       drop_words [4];

	assign cur_ids[0] = cur_q.id_w0;
	assign cur_ids[1] = cur_q.id_w1;
	assign cur_ids[2] = cur_q.id_w2;
	assign cur_ids[3] = cur_q.id_w3;
	assign prio_eff   = cfg.prio_zero ? 32'sd0 : cur_q.priority_req;
	assign idx_last   = (idx_q == SLOT_W'(QUEUE_DEPTH - 1));
	assign can_drain  = !cur_q.link_busy && ((bucket_q > 0) || cfg.no_throttle);

	always_comb begin
		id_match = 1'b1;
		lex_lt   = 1'b0;
		for (int w = 0; w < ID_WORDS; w++) begin
			if (id_q[idx_q][w] != cur_ids[w]) begin
				id_match = 1'b0;
			end
		end
		// least significant word first so the leading word decides
		for (int w = ID_WORDS - 1; w >= 0; w--) begin
			if (id_q[idx_q][w] != best_ids_q[w]) begin
				lex_lt = (id_q[idx_q][w] < best_ids_q[w]);
			end
		end
		better = valid_q[idx_q] && (!best_found_q || (prio_q[idx_q] < best_prio_q) ||
			((prio_q[idx_q] == best_prio_q) && lex_lt));
	end

	always_comb begin
		tick_sum   = ACC_W'(bucket_q) + $signed({3'b000, cfg.bytes_per_tick});
		drain_diff = ACC_W'(bucket_q) - $signed({7'b0, best_size_q});
		if (hit_found_q && !cfg.no_replace) begin
			ins_ok   = 1'b1;
			ins_slot = hit_q;
			ins_prio = (prio_eff > hit_prio_q) ? hit_prio_q : prio_eff;
		end else begin
			ins_ok   = free_found_q;
			ins_slot = free_q;
			ins_prio = prio_eff;
		end
	end

	always_comb begin
		for (int w = 0; w < 4; w++) begin
			out_words[w]  = 32'sd0;
			drop_words[w] = 32'sd0;
		end
		for (int w = 0; w < ID_WORDS; w++) begin
			out_words[w]  = best_ids_q[w];
			drop_words[w] = cur_ids[w];
		end
		drop_res = '{out_w0: drop_words[0], out_w1: drop_words[1], out_w2: drop_words[2],
			out_w3: drop_words[3], out_priority: ins_prio, out_size: cur_q.byte_size,
			dropped: 1'b1, last: 1'b0};
		emit_res = '{out_w0: out_words[0], out_w1: out_words[1], out_w2: out_words[2],
			out_w3: out_words[3], out_priority: best_prio_q, out_size: best_size_q,
			dropped: 1'b0, last: 1'b0};
		fin_res      = pend_q;
		fin_res.last = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd.mode == MODE_TICK) ? ST_DR_CHK : ST_ADD_SCAN;
				end
			end
			ST_ADD_SCAN: begin
				if (idx_last) begin
					state_d = ST_ADD_DO;
				end
			end
			ST_ADD_DO:   state_d = ST_DR_CHK;
			ST_DR_CHK:   state_d = can_drain ? ST_DR_SCAN : ST_FINISH;
			ST_DR_SCAN: begin
				if (idx_last) begin
					state_d = ST_DR_EMIT;
				end
			end
			ST_DR_EMIT:  state_d = best_found_q ? ST_DR_CHK : ST_FINISH;
			ST_FINISH:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control: valid bits, bucket, result sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			bucket_q     <= LVL_W'($signed({1'b0, BMAX_RESET}));
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.mode == MODE_TICK) begin
						if (tick_sum > $signed({3'b000, cfg.bytes_max})) begin
							bucket_q <= LVL_W'($signed({1'b0, cfg.bytes_max}));
						end else begin
							bucket_q <= tick_sum[LVL_W-1:0];
						end
					end
				end
				ST_ADD_DO: begin
					if (ins_ok) begin
						valid_q[ins_slot] <= 1'b1;
					end else begin
						pend_valid_q <= 1'b1;
					end
				end
				ST_DR_EMIT: begin
					if (best_found_q) begin
						valid_q[best_q] <= 1'b0;
						bucket_q <= (drain_diff < BUCKET_LOW) ? BUCKET_LOW[LVL_W-1:0] :
							drain_diff[LVL_W-1:0];
						pend_valid_q <= 1'b1;
						// previous result now known not to be the last one
						if (pend_valid_q) begin
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (pend_valid_q) begin
						res_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cur_q        <= cmd;
					idx_q        <= '0;
					hit_found_q  <= 1'b0;
					free_found_q <= 1'b0;
				end
			end
			ST_ADD_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (valid_q[idx_q]) begin
					if (id_match && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_q       <= idx_q;
						hit_prio_q  <= prio_q[idx_q];
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_q;
				end
			end
			ST_ADD_DO: begin
				if (ins_ok) begin
					for (int w = 0; w < ID_WORDS; w++) begin
						id_q[ins_slot][w] <= cur_ids[w];
					end
					prio_q[ins_slot] <= ins_prio;
					size_q[ins_slot] <= cur_q.byte_size;
				end else begin
					pend_q <= drop_res;
				end
			end
			ST_DR_CHK: begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
			end
			ST_DR_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (better) begin
					best_found_q <= 1'b1;
					best_q       <= idx_q;
					best_prio_q  <= prio_q[idx_q];
					best_size_q  <= size_q[idx_q];
					for (int w = 0; w < ID_WORDS; w++) begin
						best_ids_q[w] <= id_q[idx_q][w];
					end
				end
			end
			ST_DR_EMIT: begin
				if (best_found_q) begin
					pend_q <= emit_res;
					res_q  <= pend_q;
				end
			end
			ST_FINISH: begin
				res_q <= fin_res;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* hdl/throttled_priority_queue_dedup.sv */
// Top level: configuration registers, request FIFO front end, table back end.
// Depends on tpqd_pkg, tpqd_front, tpqd_back.
//
//  channel   handshake                      payload
//  request   start & !busy                  item   (in_item_t)
//  result    result_valid, one cycle        result (out_item_t)
//  config    cfg_we                         cfg_index, cfg_data
//
// An add is dispatched, scans all QUEUE_DEPTH slots and then writes one slot.
// Each drain check, when the bucket allows, is followed by a min search over
// all QUEUE_DEPTH slots and an emit step, and a search that finds the table
// empty costs a full search as well. A finish step ends every request. Up to
// FIFO_DEPTH requests queue ahead of the back end; busy is high while that
// FIFO is full. Results cannot be held off.
// Reset clears the table valid bits and loads the bucket with bytes_max.
module throttled_priority_queue_dedup
	import tpqd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        result_valid,
	output out_item_t   result
);

	cfg_t     cfg_q;
	logic     head_valid;
	in_item_t head;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bytes_per_tick: BPT_RESET, bytes_max: BMAX_RESET,
				prio_zero: 1'b0, no_replace: 1'b0, no_throttle: 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BYTES_PER_TICK: cfg_q.bytes_per_tick <= cfg_data;
				CFG_BYTES_MAX:      cfg_q.bytes_max      <= cfg_data;
				CFG_PRIO_ZERO:      cfg_q.prio_zero      <= cfg_data[0];
				CFG_NO_REPLACE:     cfg_q.no_replace     <= cfg_data[0];
				CFG_NO_THROTTLE:    cfg_q.no_throttle    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tpqd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start),
		.push_item  (item),
		.full       (busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tpqd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (head_valid),
		.cmd          (head),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* tb/sv/tb_throttled_priority_queue_dedup.sv */
// Testbench for throttled_priority_queue_dedup: random and directed requests,
// an in-bench model of the table and bucket, in-order checking of results.
// Depends on tpqd_pkg and the block's RTL.
module tb_throttled_priority_queue_dedup;
	import tpqd_pkg::*;

	localparam int LIMIT_CYCLES = 900000;
	localparam int DRAIN_WAIT   = 200;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        result_valid;
	out_item_t   result;

	throttled_priority_queue_dedup dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	// model state
	cfg_t                      m_cfg;
	logic                      m_valid [QUEUE_DEPTH] = '{default: 1'b0};
	logic signed [31:0]        m_id    [QUEUE_DEPTH][4];
	logic signed [31:0]        m_prio  [QUEUE_DEPTH];
	logic [19:0]               m_size  [QUEUE_DEPTH];
	logic signed [ACC_W-1:0]   m_level = $signed({3'b0, BMAX_RESET});

	in_item_t  pending_reqs [$];
	out_item_t expected_results [$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        idle_pct;
	bit        hold_off;
	bit        req_taken = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic queue_req(in_item_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_expected(out_item_t o);
		expected_results.insert(expected_results.size(), o);
	endtask

	function automatic bit slot_first(int a, int b);
		if (m_prio[a] != m_prio[b]) return m_prio[a] < m_prio[b];
		for (int w = 0; w < 4; w++)
			if (m_id[a][w] != m_id[b][w]) return m_id[a][w] < m_id[b][w];
		return a < b;
	endfunction

	task automatic predict_request(in_item_t r);
		out_item_t          o;
		logic signed [31:0] p;
		int                 hit, free_slot, dst, best, n0;
		logic signed [ACC_W-1:0] lvl;
		n0 = expected_results.size();
		if (r.mode == MODE_ADD) begin
			p = m_cfg.prio_zero ? 32'sd0 : r.priority_req;
			hit = -1;
			free_slot = -1;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (m_valid[i]) begin
					if (hit < 0 && m_id[i][0] == r.id_w0 && m_id[i][1] == r.id_w1 &&
					    m_id[i][2] == r.id_w2 && m_id[i][3] == r.id_w3)
						hit = i;
				end else if (free_slot < 0) free_slot = i;
			end
			if (hit >= 0 && !m_cfg.no_replace) begin
				if (p > m_prio[hit]) p = m_prio[hit];
				dst = hit;
			end else dst = free_slot;
			if (dst < 0) begin
				o = '{r.id_w0, r.id_w1, r.id_w2, r.id_w3, p, r.byte_size, 1'b1, 1'b0};
				add_expected(o);
			end else begin
				m_valid[dst] = 1'b1;
				m_id[dst] = '{r.id_w0, r.id_w1, r.id_w2, r.id_w3};
				m_prio[dst] = p;
				m_size[dst] = r.byte_size;
			end
		end else begin
			lvl = m_level + $signed({3'b0, m_cfg.bytes_per_tick});
			if (lvl > $signed({3'b0, m_cfg.bytes_max})) lvl = $signed({3'b0, m_cfg.bytes_max});
			m_level = lvl;
		end
		if (!r.link_busy) begin
			forever begin
				if (!(m_level > 0 || m_cfg.no_throttle)) break;
				best = -1;
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (m_valid[i] && (best < 0 || slot_first(i, best))) best = i;
				if (best < 0) break;
				o = '{m_id[best][0], m_id[best][1], m_id[best][2], m_id[best][3],
					m_prio[best], m_size[best], 1'b0, 1'b0};
				add_expected(o);
				m_valid[best] = 1'b0;
				lvl = m_level - $signed({7'b0, m_size[best]});
				if (lvl < BUCKET_LOW) lvl = BUCKET_LOW;
				m_level = lvl;
			end
		end
		if (expected_results.size() > n0)
			expected_results[expected_results.size()-1].last = 1'b1;
	endtask

	// driver: one request in flight on the port at a time
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else if (!start || req_taken) begin
			// req_taken says the request was accepted at the last rising edge
			if (pending_reqs.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
				item  <= pending_reqs.pop_front();
				start <= 1'b1;
			end else start <= 1'b0;
		end
	end

	// monitor: model updates on acceptance, results checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			req_taken   <= start && !busy;
			if (start && !busy) predict_request(item);
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", result);
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (result !== e) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch: expected %p got %p", e, result);
					end
				end
			end
		end else begin
			req_taken <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_word(int pool);
		case ($urandom_range(3))
			0: return $signed(32'($urandom_range(pool)));
			1: return -$signed(32'($urandom_range(pool)));
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic in_item_t make_add(logic signed [31:0] w0, logic signed [31:0] w1,
		logic signed [31:0] w2, logic signed [31:0] w3, logic signed [31:0] p,
		logic [19:0] sz, logic lb);
		return '{MODE_ADD, w0, w1, w2, w3, p, sz, lb};
	endfunction

	function automatic in_item_t rand_item();
		in_item_t r;
		logic [19:0] sz;
		sz = ($urandom_range(9) == 0) ? 20'($urandom()) : 20'($urandom_range(70000));
		r = make_add(rand_word(3), rand_word(2), rand_word(2), rand_word(3),
			rand_word(5), sz, $urandom_range(99) < 55);
		if ($urandom_range(99) < 20) r.mode = MODE_TICK;
		return r;
	endfunction

	task automatic wait_quiet();
		while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_BYTES_PER_TICK: m_cfg.bytes_per_tick = val;
			CFG_BYTES_MAX:      m_cfg.bytes_max = val;
			CFG_PRIO_ZERO:      m_cfg.prio_zero = val[0];
			CFG_NO_REPLACE:     m_cfg.no_replace = val[0];
			default:            m_cfg.no_throttle = val[0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_item_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BYTES_PER_TICK;
		cfg_data = '0;
		idle_pct = 24;
		hold_off = 1'b0;
		m_cfg = '{BPT_RESET, BMAX_RESET, 1'b0, 1'b0, 1'b0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill the table past full while the link is busy, then drain
		for (int i = 0; i < 17; i++)
			queue_req(make_add(i[0] ? 32'sh80000000 : 32'sh7fffffff,
				32'(i), i < 8 ? 32'sd0 : -32'sd1, ~32'(i), (i % 3 == 0) ? 32'sh80000000 :
				32'sh7fffffff, i[1] ? 20'hfffff : 20'd0, 1'b1));
		// same id again: replaces the size, keeps the lower stored priority; then tick and drain
		queue_req(make_add(32'sh7fffffff, 0, 32'sd0, ~32'sd0, -32'sd5, 20'h1, 1'b1));
		queue_req('{MODE_TICK, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			20'hfffff, 1'b0});
		queue_req('{MODE_TICK, '0, '0, '0, '0, '0, '0, 1'b0});
		// pause until every result has come back
		wait_quiet();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_BYTES_PER_TICK, 24'hffffff);
					write_reg(CFG_BYTES_MAX, 24'hffffff);
					write_reg(CFG_NO_REPLACE, 24'd1);
				end
				1: begin
					write_reg(CFG_BYTES_PER_TICK, 24'd0);
					write_reg(CFG_BYTES_MAX, 24'd0);
					write_reg(CFG_NO_REPLACE, 24'd0);
					write_reg(CFG_PRIO_ZERO, 24'd1);
				end
				2: begin
					write_reg(CFG_NO_THROTTLE, 24'd1);
					write_reg(CFG_PRIO_ZERO, 24'd0);
				end
				3: begin
					write_reg(CFG_NO_THROTTLE, 24'd0);
					write_reg(CFG_BYTES_PER_TICK, 24'd40000);
					write_reg(CFG_BYTES_MAX, 24'd150000);
					idle_pct = 0; // stretch with no idling
				end
				4: begin
					write_reg(CFG_BYTES_PER_TICK, 24'($urandom()));
					write_reg(CFG_BYTES_MAX, 24'($urandom()));
					idle_pct = 24;
				end
				default: begin
					write_reg(CFG_BYTES_PER_TICK, BPT_RESET);
					write_reg(CFG_BYTES_MAX, BMAX_RESET);
				end
			endcase
			for (int k = 0; k < 70; k++) begin
				r = rand_item();
				queue_req(r);
				// resend a known id now and then to hit the replace path
				if ($urandom_range(3) == 0) begin
					r.priority_req = rand_word(5);
					r.mode = MODE_ADD;
					queue_req(r);
					k++;
				end
			end
			wait_quiet();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* throttled_priority_queue_dedup.f */
hdl/tpqd_pkg.sv
hdl/tpqd_front.sv
hdl/tpqd_back.sv
hdl/throttled_priority_queue_dedup.sv
tb/sv/tb_throttled_priority_queue_dedup.sv
